// ===== hw/rtl/dllm_pkg.sv =====
// Shared types and codes for the doubly linked list manager.
`default_nettype none
package dllm_pkg;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_RM_KEY    = 3'd2;
  localparam logic [2:0] OP_RM_FRONT  = 3'd3;
  localparam logic [2:0] OP_RM_BACK   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_INS_WRITE,
    S_INS_LINK,
    S_WALK,
    S_UNL_READ,
    S_UNL_APPLY,
    S_HT_HEAD,
    S_HT_TAIL,
    S_HT_CAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       set_status;
    logic [1:0] status;
    logic       scan_init;
    logic       scan_step;
    logic       scan_take;
    logic       ins_write;
    logic       ins_link;
    logic       walk_start;
    logic       walk_step;
    logic       sel_head;
    logic       sel_tail;
    logic       unl_read;
    logic       unl_apply;
    logic       rd_head;
    logic       cap_head;
    logic       rd_tail;
    logic       cap_tail;
    logic       clear_ht;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       empty;
    logic       full;
    logic       used_bit;
    logic       match;
    logic       walk_last;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/doubly_linked_list_manager.sv =====
// Top level: bounded doubly linked list of signed 32-bit values.
// Each item passes dispatch, then its operation (free-slot scan and link for an insert, a walk
// from head for remove by key, an unlink for remove front/back), then head/tail capture and the
// result load; a refused insert, a remove on an empty list or a no-op skips the operation.
// One item at a time, next accepted in the cycle after the result loads; sync reset empties.
`default_nettype none
module doubly_linked_list_manager #(
  parameter int CAPACITY = 64
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2:0] opcode, [34:3] value, [39:35] zero
  input  wire  [dllm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [1:0] status, [8:2] entry_count, [40:9] head_value, [72:41] tail_value, [79:73] zero
  output logic [dllm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  dllm_pkg::dp_cmd_t  cmd;
  dllm_pkg::dp_stat_t stat;

  logic [1:0]                        status;
  logic [dllm_pkg::COUNT_OUT_W-1:0]  entry_count;
  logic signed [31:0]                head_value;
  logic signed [31:0]                tail_value;

  dllm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dllm_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (s_axis_tdata[2:0]),
    .in_value   (s_axis_tdata[34:3]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (status),
    .out_count  (entry_count),
    .out_head   (head_value),
    .out_tail   (tail_value)
  );

  assign m_axis_tdata = {7'd0, tail_value, head_value, entry_count, status};

endmodule
`default_nettype wire

// ===== hw/rtl/dllm_ctrl.sv =====
// Controller state machine: sequences one list operation per transaction.
`default_nettype none
module dllm_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  dllm_pkg::dp_stat_t stat,
  output dllm_pkg::dp_cmd_t  cmd
);

  dllm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dllm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dllm_pkg::S_IDLE: begin
        if (in_valid) state_next = dllm_pkg::S_DISPATCH;
      end
      dllm_pkg::S_DISPATCH: begin
        unique case (stat.opcode)
          dllm_pkg::OP_INS_FRONT, dllm_pkg::OP_INS_BACK: begin
            state_next = stat.full ? dllm_pkg::S_HT_HEAD : dllm_pkg::S_SCAN;
          end
          dllm_pkg::OP_RM_KEY: begin
            state_next = stat.empty ? dllm_pkg::S_HT_HEAD : dllm_pkg::S_WALK;
          end
          dllm_pkg::OP_RM_FRONT, dllm_pkg::OP_RM_BACK: begin
            state_next = stat.empty ? dllm_pkg::S_HT_HEAD : dllm_pkg::S_UNL_READ;
          end
          default: state_next = dllm_pkg::S_HT_HEAD;
        endcase
      end
      dllm_pkg::S_SCAN: begin
        if (!stat.used_bit) state_next = dllm_pkg::S_INS_WRITE;
      end
      dllm_pkg::S_INS_WRITE: state_next = dllm_pkg::S_INS_LINK;
      dllm_pkg::S_INS_LINK:  state_next = dllm_pkg::S_HT_HEAD;
      dllm_pkg::S_WALK: begin
        priority if (stat.match) state_next = dllm_pkg::S_UNL_READ;
        else if (stat.walk_last) state_next = dllm_pkg::S_HT_HEAD;
      end
      dllm_pkg::S_UNL_READ:  state_next = dllm_pkg::S_UNL_APPLY;
      dllm_pkg::S_UNL_APPLY: state_next = dllm_pkg::S_HT_HEAD;
      dllm_pkg::S_HT_HEAD: begin
        state_next = stat.empty ? dllm_pkg::S_DONE : dllm_pkg::S_HT_TAIL;
      end
      dllm_pkg::S_HT_TAIL: state_next = dllm_pkg::S_HT_CAP;
      dllm_pkg::S_HT_CAP:  state_next = dllm_pkg::S_DONE;
      dllm_pkg::S_DONE: begin
        if (stat.out_free) state_next = dllm_pkg::S_IDLE;
      end
      default: state_next = dllm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      dllm_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      dllm_pkg::S_DISPATCH: begin
        unique case (stat.opcode)
          dllm_pkg::OP_INS_FRONT, dllm_pkg::OP_INS_BACK: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = dllm_pkg::ST_FULL;
            end else begin
              cmd.scan_init = 1'b1;
            end
          end
          dllm_pkg::OP_RM_KEY: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = dllm_pkg::ST_MISS;
            end else begin
              cmd.walk_start = 1'b1;
            end
          end
          dllm_pkg::OP_RM_FRONT: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = dllm_pkg::ST_MISS;
            end else begin
              cmd.sel_head = 1'b1;
            end
          end
          dllm_pkg::OP_RM_BACK: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = dllm_pkg::ST_MISS;
            end else begin
              cmd.sel_tail = 1'b1;
            end
          end
          default: ;
        endcase
      end
      dllm_pkg::S_SCAN: begin
        if (stat.used_bit) cmd.scan_step = 1'b1;
        else cmd.scan_take = 1'b1;
      end
      dllm_pkg::S_INS_WRITE: cmd.ins_write = 1'b1;
      dllm_pkg::S_INS_LINK:  cmd.ins_link  = 1'b1;
      dllm_pkg::S_WALK: begin
        priority if (stat.match) begin
        end else if (stat.walk_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = dllm_pkg::ST_MISS;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      dllm_pkg::S_UNL_READ:  cmd.unl_read  = 1'b1;
      dllm_pkg::S_UNL_APPLY: cmd.unl_apply = 1'b1;
      dllm_pkg::S_HT_HEAD: begin
        if (stat.empty) cmd.clear_ht = 1'b1;
        else cmd.rd_head = 1'b1;
      end
      dllm_pkg::S_HT_TAIL: begin
        cmd.cap_head = 1'b1;
        cmd.rd_tail  = 1'b1;
      end
      dllm_pkg::S_HT_CAP: cmd.cap_tail = 1'b1;
      dllm_pkg::S_DONE:   cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dllm_datapath.sv =====
// Datapath: slot memories, head/tail/count registers, used map and result register.
`default_nettype none
module dllm_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  dllm_pkg::dp_cmd_t            cmd,
  output dllm_pkg::dp_stat_t           stat,
  input  wire  [2:0]                   in_opcode,
  input  wire  signed [31:0]           in_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic [dllm_pkg::COUNT_OUT_W-1:0] out_count,
  output logic signed [31:0]           out_head,
  output logic signed [31:0]           out_tail
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]         data_mem [CAPACITY];
  logic [SW-1:0]       next_mem [CAPACITY];
  logic [SW-1:0]       prev_mem [CAPACITY];
  logic [31:0]         data_q;
  logic [SW-1:0]       next_q;
  logic [SW-1:0]       prev_q;

  logic [2:0]          op;
  logic [31:0]         key;
  logic [1:0]          status;
  logic [SW-1:0]       head;
  logic [SW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [CAPACITY-1:0] used_map;
  logic [SW-1:0]       cur;
  logic [SW-1:0]       idx;
  logic [CW-1:0]       walk_k;
  logic [31:0]         head_val;
  logic [31:0]         tail_val;

  logic                is_front;
  logic                count_one;
  logic                unl_middle;

  logic                data_we, data_re;
  logic [SW-1:0]       data_ra;
  logic                next_we, next_re;
  logic [SW-1:0]       next_wa, next_wd, next_ra;
  logic                prev_we, prev_re;
  logic [SW-1:0]       prev_wa, prev_wd, prev_ra;

  assign is_front   = (op == dllm_pkg::OP_INS_FRONT);
  assign count_one  = (count == CW'(1));
  assign unl_middle = !count_one && (cur != head) && (cur != tail);

  assign stat.opcode    = op;
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.used_bit  = used_map[idx];
  assign stat.match     = (data_q == key);
  assign stat.walk_last = ((walk_k + CW'(1)) == count);
  assign stat.out_free  = !out_valid || out_ready;

  // Memory port control
  always_comb begin
    data_we = cmd.ins_write;
    data_re = cmd.walk_start || cmd.walk_step || cmd.rd_head || cmd.rd_tail;
    data_ra = head;
    if (cmd.walk_step) data_ra = next_q;
    else if (cmd.rd_tail) data_ra = tail;

    next_re = cmd.walk_start || cmd.walk_step || cmd.unl_read;
    next_ra = head;
    if (cmd.walk_step) next_ra = next_q;
    else if (cmd.unl_read) next_ra = cur;

    prev_re = cmd.unl_read;
    prev_ra = cur;

    next_we = 1'b0;
    next_wa = cur;
    next_wd = cur;
    prev_we = 1'b0;
    prev_wa = cur;
    prev_wd = cur;
    if (cmd.ins_write) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      // new entry points at itself at the open end
      if (count != '0 && is_front) next_wd = head;
      if (count != '0 && !is_front) prev_wd = tail;
    end else if (cmd.ins_link) begin
      if (count != '0) begin
        if (is_front) begin
          prev_we = 1'b1;
          prev_wa = head;
        end else begin
          next_we = 1'b1;
          next_wa = tail;
        end
      end
    end else if (cmd.unl_apply && unl_middle) begin
      next_we = 1'b1;
      next_wa = prev_q;
      next_wd = next_q;
      prev_we = 1'b1;
      prev_wa = next_q;
      prev_wd = prev_q;
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[cur] <= key;
    if (data_re) data_q <= data_mem[data_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_q <= prev_mem[prev_ra];
  end

  // List control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      used_map <= '0;
    end else if (cmd.ins_link) begin
      used_map[cur] <= 1'b1;
      count         <= count + CW'(1);
      if (count == '0) begin
        head <= cur;
        tail <= cur;
      end else if (is_front) begin
        head <= cur;
      end else begin
        tail <= cur;
      end
    end else if (cmd.unl_apply) begin
      used_map[cur] <= 1'b0;
      count         <= count - CW'(1);
      priority if (count_one) begin
        head <= '0;
        tail <= '0;
      end else if (cur == head) begin
        head <= next_q;
      end else if (cur == tail) begin
        tail <= prev_q;
      end
    end
  end

  // Per-transaction working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op     <= in_opcode;
      key    <= in_value;
      status <= dllm_pkg::ST_OK;
    end
    if (cmd.set_status) status <= cmd.status;
    if (cmd.scan_init) idx <= '0;
    if (cmd.scan_step) idx <= idx + SW'(1);
    if (cmd.scan_take) cur <= idx;
    if (cmd.sel_head) cur <= head;
    if (cmd.sel_tail) cur <= tail;
    if (cmd.walk_start) begin
      cur    <= head;
      walk_k <= '0;
    end
    if (cmd.walk_step) begin
      cur    <= next_q;
      walk_k <= walk_k + CW'(1);
    end
    if (cmd.clear_ht) begin
      head_val <= '0;
      tail_val <= '0;
    end
    if (cmd.cap_head) head_val <= data_q;
    if (cmd.cap_tail) tail_val <= data_q;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= status;
      out_count  <= dllm_pkg::COUNT_OUT_W'(count);
      out_head   <= head_val;
      out_tail   <= tail_val;
    end
  end

endmodule
`default_nettype wire
